[src/yuyvds_pkg.sv]
// Shared types and constants for the YUYV nearest-neighbor downscaler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package yuyvds_pkg;

   localparam int MAX_SOURCE_DIM = 4096;
   localparam int MAX_TARGET_DIM = 256;

   localparam int SRC_DIM_W = 13;
   localparam int TGT_DIM_W = 9;
   localparam int SUM_W     = 22;

   localparam logic [SRC_DIM_W-1:0] RESET_SOURCE_WIDTH  = 13'd1280;
   localparam logic [SRC_DIM_W-1:0] RESET_SOURCE_HEIGHT = 13'd720;
   localparam logic [TGT_DIM_W-1:0] RESET_TARGET_WIDTH  = 9'd256;
   localparam logic [TGT_DIM_W-1:0] RESET_TARGET_HEIGHT = 9'd144;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
   localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // effective (clamped, evened) frame dimensions
   typedef struct packed {
      logic [SRC_DIM_W-1:0] sw;
      logic [SRC_DIM_W-1:0] sh;
      logic [TGT_DIM_W-1:0] tw;
      logic [TGT_DIM_W-1:0] th;
   } dims_type;

   typedef struct packed {
      logic       frame_done;
      logic [7:0] chroma_red;
      logic [7:0] luma_b;
      logic [7:0] chroma_blue;
      logic [7:0] luma_a;
   } result_type;

endpackage

[src/yuyvds_csr.sv]
// Configuration registers of the downscaler with APB-style access.
// Produces the clamped effective dimensions. Depends on yuyvds_pkg.
`timescale 1ns / 1ps

module yuyvds_csr
   import yuyvds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output dims_type    dims
);

   logic [SRC_DIM_W-1:0] source_width_ff, source_width_in;
   logic [SRC_DIM_W-1:0] source_height_ff, source_height_in;
   logic [TGT_DIM_W-1:0] target_width_ff, target_width_in;
   logic [TGT_DIM_W-1:0] target_height_ff, target_height_in;
   logic                 write_en;

   function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [SRC_DIM_W-1:0] v,
                                                      input logic [SRC_DIM_W-1:0] lo,
                                                      input logic make_even);
      logic [SRC_DIM_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > SRC_DIM_W'(MAX_SOURCE_DIM)) begin
         r = SRC_DIM_W'(MAX_SOURCE_DIM);
      end else begin
         r = v;
      end
      if (make_even) begin
         r[0] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [TGT_DIM_W-1:0] clamp_tgt(input logic [TGT_DIM_W-1:0] v,
                                                      input logic [TGT_DIM_W-1:0] lo,
                                                      input logic make_even);
      logic [TGT_DIM_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > TGT_DIM_W'(MAX_TARGET_DIM)) begin
         r = TGT_DIM_W'(MAX_TARGET_DIM);
      end else begin
         r = v;
      end
      if (make_even) begin
         r[0] = 1'b0;
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      source_width_in  = source_width_ff;
      source_height_in = source_height_ff;
      target_width_in  = target_width_ff;
      target_height_in = target_height_ff;
      if (write_en) begin
         unique case (csr_paddr[3:2])
            REG_SOURCE_WIDTH:  source_width_in  = csr_pwdata[SRC_DIM_W-1:0];
            REG_SOURCE_HEIGHT: source_height_in = csr_pwdata[SRC_DIM_W-1:0];
            REG_TARGET_WIDTH:  target_width_in  = csr_pwdata[TGT_DIM_W-1:0];
            REG_TARGET_HEIGHT: target_height_in = csr_pwdata[TGT_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SOURCE_WIDTH:  csr_prdata = 32'(source_width_ff);
         REG_SOURCE_HEIGHT: csr_prdata = 32'(source_height_ff);
         REG_TARGET_WIDTH:  csr_prdata = 32'(target_width_ff);
         REG_TARGET_HEIGHT: csr_prdata = 32'(target_height_ff);
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= RESET_SOURCE_WIDTH;
         source_height_ff <= RESET_SOURCE_HEIGHT;
         target_width_ff  <= RESET_TARGET_WIDTH;
         target_height_ff <= RESET_TARGET_HEIGHT;
      end else begin
         source_width_ff  <= source_width_in;
         source_height_ff <= source_height_in;
         target_width_ff  <= target_width_in;
         target_height_ff <= target_height_in;
      end
   end

   assign dims.sw = clamp_src(source_width_ff, SRC_DIM_W'(2), 1'b1);
   assign dims.sh = clamp_src(source_height_ff, SRC_DIM_W'(1), 1'b0);
   assign dims.tw = clamp_tgt(target_width_ff, TGT_DIM_W'(2), 1'b1);
   assign dims.th = clamp_tgt(target_height_ff, TGT_DIM_W'(1), 1'b0);

endmodule

[src/yuyvds_front.sv]
// Front end: tracks source/output position, picks the kept pixels of each
// request and emits completed output pairs to the queue. Depends on yuyvds_pkg.
`timescale 1ns / 1ps

module yuyvds_front
   import yuyvds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dims_type    dims,
   input  logic        accept,
   input  logic [31:0] in_data,
   input  logic        in_frame_begin,
   output logic        push,
   output result_type  push_data
);

   logic [SRC_DIM_W-1:0] src_column_ff, src_column_in;
   logic [SRC_DIM_W-1:0] src_line_ff, src_line_in;
   logic [TGT_DIM_W-1:0] dst_column_ff, dst_column_in;
   logic [TGT_DIM_W-1:0] dst_line_ff, dst_line_in;
   logic [SUM_W-1:0]     col_tgt_sum_ff, col_tgt_sum_in;
   logic [SUM_W-1:0]     col_src_sum_ff, col_src_sum_in;
   logic [SUM_W-1:0]     line_tgt_sum_ff, line_tgt_sum_in;
   logic [SUM_W-1:0]     line_src_sum_ff, line_src_sum_in;
   logic                 line_kept_ff, line_kept_in;
   logic [23:0]          held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;

   // base state after an optional frame restart
   logic [SRC_DIM_W-1:0] b_sc, b_sl;
   logic [TGT_DIM_W-1:0] b_dc, b_dl;
   logic [SUM_W-1:0]     b_cts, b_css, b_lts, b_lss;
   logic                 b_keep, b_hv;
   logic [23:0]          b_hs;

   logic [SUM_W-1:0]     sw_s, sh_s, tw_s, th_s;
   logic [7:0]           ya, u, yb, v;
   logic                 take0, take1, res0, res1;
   logic [TGT_DIM_W-1:0] dc1, dc2;
   logic [SUM_W-1:0]     cts1, cts2, css1, css2;
   logic                 hv1, hv2;
   logic [23:0]          hs1, hs2;
   result_type           e0, e1;
   logic [SRC_DIM_W-1:0] sc2, sl_n;
   logic [TGT_DIM_W-1:0] dl_n;
   logic [SUM_W-1:0]     lts_n, lss_n;
   logic                 line_end;

   assign ya = in_data[7:0];
   assign u  = in_data[15:8];
   assign yb = in_data[23:16];
   assign v  = in_data[31:24];

   assign sw_s = SUM_W'(dims.sw);
   assign sh_s = SUM_W'(dims.sh);
   assign tw_s = SUM_W'(dims.tw);
   assign th_s = SUM_W'(dims.th);

   always_comb begin
      if (in_frame_begin) begin
         b_sc = '0; b_sl = '0; b_dc = '0; b_dl = '0;
         b_cts = '0; b_css = '0; b_lts = '0; b_lss = '0;
         b_keep = 1'b1; b_hv = 1'b0; b_hs = '0;
      end else begin
         b_sc = src_column_ff; b_sl = src_line_ff;
         b_dc = dst_column_ff; b_dl = dst_line_ff;
         b_cts = col_tgt_sum_ff; b_css = col_src_sum_ff;
         b_lts = line_tgt_sum_ff; b_lss = line_src_sum_ff;
         b_keep = line_kept_ff; b_hv = held_valid_ff; b_hs = held_ff;
      end
   end

   // even source pixel
   always_comb begin
      take0 = b_keep && (b_dc < dims.tw) && (b_cts < b_css + tw_s);
      res0  = 1'b0;
      hv1   = b_hv;
      hs1   = b_hs;
      e0.luma_a      = b_hs[23:16];
      e0.chroma_blue = b_hs[15:8];
      e0.luma_b      = ya;
      e0.chroma_red  = b_hs[7:0];
      e0.frame_done  = ((b_dl + 9'd1) == dims.th) && ((b_dc + 9'd1) == dims.tw);
      if (take0) begin
         if (!b_dc[0]) begin
            hs1 = {ya, u, v};
            hv1 = 1'b1;
         end else if (b_hv) begin
            res0 = 1'b1;
            hv1  = 1'b0;
         end
      end
      dc1  = b_dc + TGT_DIM_W'(take0);
      cts1 = take0 ? b_cts + sw_s : b_cts;
      css1 = b_css + tw_s;
   end

   // odd source pixel
   always_comb begin
      take1 = b_keep && (dc1 < dims.tw) && (cts1 < css1 + tw_s);
      res1  = 1'b0;
      hv2   = hv1;
      hs2   = hs1;
      e1.luma_a      = hs1[23:16];
      e1.chroma_blue = hs1[15:8];
      e1.luma_b      = yb;
      e1.chroma_red  = hs1[7:0];
      e1.frame_done  = ((b_dl + 9'd1) == dims.th) && ((dc1 + 9'd1) == dims.tw);
      if (take1) begin
         if (!dc1[0]) begin
            hs2 = {yb, u, v};
            hv2 = 1'b1;
         end else if (hv1) begin
            res1 = 1'b1;
            hv2  = 1'b0;
         end
      end
      dc2  = dc1 + TGT_DIM_W'(take1);
      cts2 = take1 ? cts1 + sw_s : cts1;
      css2 = css1 + tw_s;
   end

   assign sc2      = b_sc + SRC_DIM_W'(2);
   assign line_end = sc2 >= dims.sw;
   assign dl_n     = b_keep ? b_dl + 9'd1 : b_dl;
   assign lts_n    = b_keep ? b_lts + sh_s : b_lts;
   assign sl_n     = b_sl + SRC_DIM_W'(1);
   assign lss_n    = b_lss + th_s;

   always_comb begin
      src_column_in   = src_column_ff;
      src_line_in     = src_line_ff;
      dst_column_in   = dst_column_ff;
      dst_line_in     = dst_line_ff;
      col_tgt_sum_in  = col_tgt_sum_ff;
      col_src_sum_in  = col_src_sum_ff;
      line_tgt_sum_in = line_tgt_sum_ff;
      line_src_sum_in = line_src_sum_ff;
      line_kept_in    = line_kept_ff;
      held_in         = held_ff;
      held_valid_in   = held_valid_ff;
      if (accept) begin
         if (line_end) begin
            src_column_in  = '0;
            dst_column_in  = '0;
            col_tgt_sum_in = '0;
            col_src_sum_in = '0;
            held_in        = '0;
            held_valid_in  = 1'b0;
            if (sl_n >= dims.sh) begin
               // wrap into a new frame
               src_line_in     = '0;
               dst_line_in     = '0;
               line_tgt_sum_in = '0;
               line_src_sum_in = '0;
               line_kept_in    = 1'b1;
            end else begin
               src_line_in     = sl_n;
               dst_line_in     = dl_n;
               line_tgt_sum_in = lts_n;
               line_src_sum_in = lss_n;
               line_kept_in    = (dl_n < dims.th) && (lts_n < lss_n + th_s);
            end
         end else begin
            src_column_in   = sc2;
            dst_column_in   = dc2;
            col_tgt_sum_in  = cts2;
            col_src_sum_in  = css2;
            held_in         = hs2;
            held_valid_in   = hv2;
            src_line_in     = b_sl;
            dst_line_in     = b_dl;
            line_tgt_sum_in = b_lts;
            line_src_sum_in = b_lss;
            line_kept_in    = b_keep;
         end
      end
   end

   assign push      = accept && (res0 || res1);
   assign push_data = res0 ? e0 : e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_column_ff   <= '0;
         src_line_ff     <= '0;
         dst_column_ff   <= '0;
         dst_line_ff     <= '0;
         col_tgt_sum_ff  <= '0;
         col_src_sum_ff  <= '0;
         line_tgt_sum_ff <= '0;
         line_src_sum_ff <= '0;
         line_kept_ff    <= 1'b1;
         held_ff         <= '0;
         held_valid_ff   <= 1'b0;
      end else begin
         src_column_ff   <= src_column_in;
         src_line_ff     <= src_line_in;
         dst_column_ff   <= dst_column_in;
         dst_line_ff     <= dst_line_in;
         col_tgt_sum_ff  <= col_tgt_sum_in;
         col_src_sum_ff  <= col_src_sum_in;
         line_tgt_sum_ff <= line_tgt_sum_in;
         line_src_sum_ff <= line_src_sum_in;
         line_kept_ff    <= line_kept_in;
         held_ff         <= held_in;
         held_valid_ff   <= held_valid_in;
      end
   end

endmodule

[src/yuyvds_queue.sv]
// Short FIFO between the front end and the output stage.
// Depends on yuyvds_pkg.
`timescale 1ns / 1ps

module yuyvds_queue
   import yuyvds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       not_full,
   output logic       not_empty,
   output result_type head
);

   result_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign not_full  = count_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");

endmodule

[src/yuyvds_back.sv]
// Output stage: registers the queue head onto the result channel.
// Depends on yuyvds_pkg.
`timescale 1ns / 1ps

module yuyvds_back
   import yuyvds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  result_type  q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // refill whenever the register is empty or being drained this cycle
   assign q_pop = q_not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      data_in = q_pop ? q_head : data_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.chroma_red, data_ff.luma_b,
                        data_ff.chroma_blue, data_ff.luma_a};
   assign rsp_tlast  = data_ff.frame_done;

endmodule

[src/yuyv_nearest_downscaler.sv]
// Top level of the YUYV nearest-neighbor downscaler.
// Instantiates yuyvds_csr, yuyvds_front, yuyvds_queue and yuyvds_back; uses yuyvds_pkg.
`timescale 1ns / 1ps
//
// Usage:
//  - req_* carries one source YUYV pair per request, in raster order;
//    req_tuser marks the first pair of a source frame.
//  - rsp_* carries one output YUYV pair per response; rsp_tlast marks the
//    last output pair of the frame.
//  - csr_* sets source and target dimensions; write only while idle.
//    Out-of-range sizes are clamped, widths forced even.
//  - Throughput: one request per clock while the queue is not full. Each request yields zero
//    or one response, computed in the front end in the accept cycle.
//  - Path: a response is written into the queue when the request that
//    completes it is accepted, then moves into the output register.
//  - Reset loads 1280x720 -> 256x144, clears the frame position and empties
//    the queue.
//  - Receiver stall: the 4-entry queue plus the output register absorb
//    responses; req_tready drops only when the queue is full.

module yuyv_nearest_downscaler
   import yuyvds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // luma_a, chroma_blue, luma_b, chroma_red
   input  logic        req_tuser,   // frame_begin
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_luma_a, out_chroma_blue, out_luma_b, out_chroma_red
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dims_type   dims;
   logic       accept;
   logic       push;
   result_type push_data;
   logic       q_not_full;
   logic       q_not_empty;
   logic       q_pop;
   result_type q_head;

   assign req_tready = q_not_full;
   assign accept     = req_tvalid && req_tready;

   yuyvds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   yuyvds_front u_front (
      .clock          (clock),
      .reset          (reset),
      .dims           (dims),
      .accept         (accept),
      .in_data        (req_tdata),
      .in_frame_begin (req_tuser),
      .push           (push),
      .push_data      (push_data)
   );

   yuyvds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   yuyvds_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[tb/tb_yuyv_nearest_downscaler.sv]
// Self-checking testbench for the YUYV nearest-neighbor downscaler: a directed table, then
// random frames under several sizes, each response checked against its row or a predictor.
// Depends on yuyvds_pkg and yuyv_nearest_downscaler.
`timescale 1ns / 1ps

module tb_yuyv_nearest_downscaler;
   import yuyvds_pkg::*;

   localparam int TOTAL_PAIRS   = 656;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0] luma_a;
      logic [7:0] chroma_blue;
      logic [7:0] luma_b;
      logic [7:0] chroma_red;
      logic       frame_begin;
   } src_pair_type;

   typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   index;        // register, write rows only
      logic [31:0]  word;         // pwdata, or {V, Y1, U, Y0}
      logic         frame_begin;
      logic         typed;        // response given in the row
      logic [32:0]  response;     // {frame_done, V, Y1, U, Y0}
   } stim_row_type;

   // reset dims first, then every register at its low clamp (2x1 -> 2x1): each request
   // comes straight back as one pair that closes the frame
   localparam int DIRECTED_ROWS = 16;
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h0000_0000, 1'b1, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'hFFFF_FFFF, 1'b0, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h55AA_55AA, 1'b0, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'hAA55_AA55, 1'b0, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h0F0F_F0F0, 1'b1, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'hFFFF_0000, 1'b0, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h00FF_FF00, 1'b0, 1'b0, 33'h0},
      '{ROW_WRITE, REG_SOURCE_WIDTH,  32'h0000_0000, 1'b0, 1'b0, 33'h0},
      '{ROW_WRITE, REG_SOURCE_HEIGHT, 32'h0000_0000, 1'b0, 1'b0, 33'h0},
      '{ROW_WRITE, REG_TARGET_WIDTH,  32'h0000_0000, 1'b0, 1'b0, 33'h0},
      '{ROW_WRITE, REG_TARGET_HEIGHT, 32'h0000_0000, 1'b0, 1'b0, 33'h0},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h0000_0000, 1'b1, 1'b1, 33'h1_0000_0000},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFF},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'hA5A5_5A5A, 1'b1, 1'b1, 33'h1_A5A5_5A5A},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h5A5A_A5A5, 1'b0, 1'b1, 33'h1_5A5A_A5A5},
      '{ROW_PAIR,  REG_SOURCE_WIDTH,  32'h0123_4567, 1'b0, 1'b1, 33'h1_0123_4567}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // luma_a, chroma_blue, luma_b, chroma_red
   logic        req_tuser;    // frame_begin
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // out_luma_a, out_chroma_blue, out_luma_b, out_chroma_red
   logic        rsp_tlast;    // frame_done
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   yuyv_nearest_downscaler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: raw register values and the frame position
   logic [12:0] cfg_source_width, cfg_source_height;
   logic [8:0]  cfg_target_width, cfg_target_height;
   int unsigned src_col, src_row, dst_col, dst_row;
   int unsigned col_dst_acc, col_src_acc, row_dst_acc, row_src_acc;
   bit          row_used;
   logic [7:0]  pend_luma, pend_blue, pend_red;
   bit          pend_valid;

   result_type expected_pairs[$];
   int         error_count = 0;
   int         pairs_sent = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         hold_request = 1'b0;

   function automatic void log_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t ns: %s", $time, msg);
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void restart_row();
      src_col     = 0;
      dst_col     = 0;
      col_dst_acc = 0;
      col_src_acc = 0;
      pend_valid  = 1'b0;
   endfunction

   function automatic void restart_frame();
      restart_row();
      src_row     = 0;
      dst_row     = 0;
      row_dst_acc = 0;
      row_src_acc = 0;
      row_used    = 1'b1;
   endfunction

   // advances the frame position by one source pair; returns 1 when an output pair completes
   function automatic bit scale_pair(input src_pair_type p, output result_type r);
      int unsigned sw, sh, tw, th;
      logic [7:0]  luma;
      bit          produced;
      sw = clamp_dim(cfg_source_width, 2, MAX_SOURCE_DIM) & ~32'd1;
      sh = clamp_dim(cfg_source_height, 1, MAX_SOURCE_DIM);
      tw = clamp_dim(cfg_target_width, 2, MAX_TARGET_DIM) & ~32'd1;
      th = clamp_dim(cfg_target_height, 1, MAX_TARGET_DIM);
      produced = 1'b0;
      r = '0;
      if (p.frame_begin)
         restart_frame();
      for (int q = 0; q < 2; q++) begin
         luma = (q == 0) ? p.luma_a : p.luma_b;
         if (row_used && dst_col < tw && col_dst_acc < col_src_acc + tw) begin
            if (dst_col % 2 == 0) begin
               pend_luma  = luma;
               pend_blue  = p.chroma_blue;
               pend_red   = p.chroma_red;
               pend_valid = 1'b1;
            end else if (pend_valid) begin
               r.luma_a      = pend_luma;
               r.chroma_blue = pend_blue;
               r.luma_b      = luma;
               r.chroma_red  = pend_red;
               r.frame_done  = (dst_row + 1 == th) && (dst_col + 1 == tw);
               pend_valid    = 1'b0;
               produced      = 1'b1;
            end
            dst_col++;
            col_dst_acc += sw;
         end
         col_src_acc += tw;
      end
      src_col += 2;
      if (src_col >= sw) begin
         if (row_used) begin
            dst_row++;
            row_dst_acc += sh;
         end
         src_row++;
         row_src_acc += th;
         restart_row();
         if (src_row >= sh)
            restart_frame();
         else
            row_used = (dst_row < th) && (row_dst_acc < row_src_acc + th);
      end
      return produced;
   endfunction

   function automatic src_pair_type random_pair(input bit frame_begin);
      src_pair_type p;
      {p.luma_a, p.chroma_blue, p.luma_b, p.chroma_red} = $urandom;
      p.frame_begin = frame_begin;
      return p;
   endfunction

   task automatic send_pair(input src_pair_type p, input bit typed, input result_type given);
      result_type predicted;
      if (pairs_sent < TOTAL_PAIRS / 3) begin
         send_idle_pct = 30;
         recv_idle_pct = 54;
      end else if (pairs_sent < 2 * TOTAL_PAIRS / 3) begin
         send_idle_pct = 54;
         recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.chroma_red, p.luma_b, p.chroma_blue, p.luma_a};
      req_tuser  <= p.frame_begin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (scale_pair(p, predicted) && !typed)
         expected_pairs = {expected_pairs, predicted};
      if (typed)
         expected_pairs = {expected_pairs, given};
      pairs_sent++;
   endtask

   // stop requests and let every pending response come out before touching registers
   task automatic drain_responses();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_pairs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pairs.size() != 0) begin
         log_error($sformatf("%0d expected responses never arrived", expected_pairs.size()));
         expected_pairs.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (index)
         REG_SOURCE_WIDTH:  cfg_source_width  = value[12:0];
         REG_SOURCE_HEIGHT: cfg_source_height = value[12:0];
         REG_TARGET_WIDTH:  cfg_target_width  = value[8:0];
         REG_TARGET_HEIGHT: cfg_target_height = value[8:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int sw, input int sh, input int tw, input int th);
      drain_responses();
      csr_write(REG_SOURCE_WIDTH, sw);
      csr_write(REG_SOURCE_HEIGHT, sh);
      csr_write(REG_TARGET_WIDTH, tw);
      csr_write(REG_TARGET_HEIGHT, th);
   endtask

   initial begin : response_monitor
      result_type got, want;
      int         held_for;
      held_for = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = result_type'({rsp_tlast, rsp_tdata});
            if (expected_pairs.size() == 0) begin
               log_error($sformatf("response with nothing pending: %h", got));
            end else begin
               want = expected_pairs.pop_front();
               if (got.luma_a !== want.luma_a || got.chroma_blue !== want.chroma_blue ||
                   got.luma_b !== want.luma_b || got.chroma_red !== want.chroma_red ||
                   got.frame_done !== want.frame_done)
                  log_error($sformatf(
                     "exp Y0 %h U %h Y1 %h V %h last %b, got Y0 %h U %h Y1 %h V %h last %b",
                     want.luma_a, want.chroma_blue, want.luma_b, want.chroma_red,
                     want.frame_done, got.luma_a, got.chroma_blue, got.luma_b,
                     got.chroma_red, got.frame_done));
            end
         end
         // long hold-off: the queue fills and the input side has to stall
         if (hold_request) begin
            rsp_tready <= 1'b0;
            held_for++;
            if (held_for >= HOLD_CYCLES) begin
               hold_request = 1'b0;
               held_for = 0;
            end
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : timeout_guard
      #2_000_000;
      $display("tb_yuyv_nearest_downscaler: done, errors");
      $finish;
   end

   initial begin : stimulus
      src_pair_type p;
      int           phase_no, frames, frame_len, frame_pairs;
      bit           pressure_done;
      phase_no      = 0;
      pressure_done = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cfg_source_width  = RESET_SOURCE_WIDTH;
      cfg_source_height = RESET_SOURCE_HEIGHT;
      cfg_target_width  = RESET_TARGET_WIDTH;
      cfg_target_height = RESET_TARGET_HEIGHT;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (i == 0 || directed_rows[i-1].kind != ROW_WRITE)
               drain_responses();
            csr_write(directed_rows[i].index, directed_rows[i].word);
         end else begin
            {p.chroma_red, p.luma_b, p.chroma_blue, p.luma_a} = directed_rows[i].word;
            p.frame_begin = directed_rows[i].frame_begin;
            send_pair(p, directed_rows[i].typed, result_type'(directed_rows[i].response));
         end
      end

      while (pairs_sent < TOTAL_PAIRS) begin
         if (phase_no == 0) begin
            // high clamps: 4096x4096 -> 256x256, staying within the first line
            configure(8191, 8191, 511, 511);
            for (int j = 0; j < 40; j++)
               send_pair(random_pair(j == 0), 1'b0, '0);
         end else if (phase_no == 1) begin
            // source far narrower than the target
            configure(0, 8191, 511, 0);
            for (int j = 0; j < 24; j++)
               send_pair(random_pair(j == 0), 1'b0, '0);
         end else if (!pressure_done && pairs_sent >= 2 * TOTAL_PAIRS / 3) begin
            configure(3, 1, 3, 1);
            pressure_done = 1'b1;
            hold_request = 1'b1;
            for (int j = 0; j < 40; j++)
               send_pair(random_pair($urandom_range(1)), 1'b0, '0);
         end else begin
            // mostly new sizes; sometimes keep them and carry on mid-frame
            if ($urandom_range(7) != 0) begin
               if ($urandom_range(4) == 0)
                  configure($urandom_range(24), $urandom_range(6),
                            $urandom_range(40), $urandom_range(8));
               else begin
                  frame_len = $urandom_range(24);
                  frames    = $urandom_range(6);
                  configure(frame_len, frames, $urandom_range(frame_len),
                            $urandom_range(frames));
               end
            end
            frame_pairs = (clamp_dim(cfg_source_width, 2, MAX_SOURCE_DIM) / 2) *
                          clamp_dim(cfg_source_height, 1, MAX_SOURCE_DIM);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               frame_len = ($urandom_range(3) != 0) ? frame_pairs
                                                    : $urandom_range(1, frame_pairs + 3);
               for (int j = 0; j < frame_len; j++)
                  send_pair(random_pair((j == 0) ? ($urandom_range(99) < 85)
                                                 : ($urandom_range(99) < 3)), 1'b0, '0);
            end
         end
         phase_no++;
      end

      drain_responses();
      if (error_count == 0)
         $display("tb_yuyv_nearest_downscaler: done, clean");
      else
         $display("tb_yuyv_nearest_downscaler: done, errors");
      $finish;
   end

endmodule
